// ===== src/iqmdb_pkg.sv =====
// ----------------------------------------------------------------------------
// iqmdb_pkg
// Shared types and constants for the IQ magnitude / dB power detector.
// ----------------------------------------------------------------------------
package iqmdb_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MANT_BITS  = 32;
  localparam int REF_BITS   = 32;
  localparam int REF_NW     = 5;
  localparam int RES_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int SCALE_W    = 27;

  // round(10*log10(2) * 2^8 * 2^16)
  localparam logic signed [SCALE_W-1:0] DB_SCALE = 27'sd50504453;
  localparam logic signed [RES_W-1:0]   DB_MIN   = -17'sd32768;
  localparam logic signed [RES_W-1:0]   DB_MAX   = 17'sd32767;
  localparam logic [15:0]               MAG_MAX  = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_IN_DB    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_POWER = 1'd1;

  typedef struct packed {
    logic valid;
    logic last;
    logic db;
    logic zero;
  } ctl_t;

endpackage

// ===== src/iqmdb_if.sv =====
// ----------------------------------------------------------------------------
// iqmdb_in_if / iqmdb_out_if
// Valid/ready channels for samples in and results out.
// ----------------------------------------------------------------------------
interface iqmdb_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_phase_sample;
  logic signed [SAMPLE_BITS-1:0] quadrature_sample;
  logic                          last_sample;

  modport source (output valid, in_phase_sample, quadrature_sample, last_sample,
                  input ready);
  modport sink   (input valid, in_phase_sample, quadrature_sample, last_sample,
                  output ready);
endinterface

interface iqmdb_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] result_value;
  logic               last_result;

  modport source (output valid, result_value, last_result, input ready);
  modport sink   (input valid, result_value, last_result, output ready);
endinterface

// ===== src/iq_magnitude_and_db_power.sv =====
// ----------------------------------------------------------------------------
// iq_magnitude_and_db_power
// Complex magnitude (integer sqrt of I*I+Q*Q) or 10*log10(P/ref) in Q7.8.
// ----------------------------------------------------------------------------
// Fully pipelined: one sample beat accepted per cycle while the pipe advances,
// one result beat per sample. A chain of cells resolves up to one sqrt digit
// and one log2 fraction bit each. The whole pipe advances whenever the output
// register is empty or being taken. Zero power reads -32768 in dB mode; a zero
// reference counts as one. The user must write configuration only while no
// beats are in flight; the block itself does not enforce this.
module iq_magnitude_and_db_power
  import iqmdb_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  iqmdb_in_if.sink              in_i,
  iqmdb_out_if.source           out_o
);

  localparam int SB  = SAMPLE_BITS;
  localparam int PW  = 2 * SB;
  localparam int NW  = $clog2(PW);
  localparam int NC  = (SB > FRAC_BITS) ? SB : FRAC_BITS;
  localparam int LNW = (NW > REF_NW) ? NW : REF_NW;
  localparam int DW  = LNW + FRAC_BITS + 1;
  localparam int PRW = DW + SCALE_W;
  localparam int RW  = PRW - 32;

  // configuration
  logic                db_q;
  logic [REF_BITS-1:0] ref_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_q  <= 1'b0;
      ref_q <= REF_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OUTPUT_IN_DB:    db_q  <= cfg_data_i[0];
        REG_REFERENCE_POWER: ref_q <= cfg_data_i[REF_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // stage 1: input register
  ctl_t                   c1_q;
  logic signed [SB-1:0]   i1_q, q1_q;
  // stage 2: squares
  ctl_t                   c2_q;
  logic [PW-1:0]          si2_q, sq2_q;
  // stage 3: power
  ctl_t                   c3_q;
  logic [PW-1:0]          p3_q;
  logic [REF_BITS-1:0]    r3_q;
  // stage 4: leading one position
  ctl_t                   c4_q;
  logic [PW-1:0]          p4_q;
  logic [REF_BITS-1:0]    r4_q;
  logic [NW-1:0]          np4_q, np4_d;
  logic [REF_NW-1:0]      nr4_q, nr4_d;
  // stage 5: normalized mantissas
  ctl_t                   c5_q;
  logic [PW-1:0]          p5_q;
  logic [MANT_BITS-1:0]   mp5_q, mp5_d, mr5_q, mr5_d;
  logic [NW-1:0]          np5_q;
  logic [REF_NW-1:0]      nr5_q;
  logic [PW-1:0]          shp;
  logic [REF_BITS-1:0]    shr;

  always_comb begin
    np4_d = '0;
    for (int b = 0; b < PW; b++) begin
      if (p3_q[b]) np4_d = NW'(b);
    end
    nr4_d = '0;
    for (int b = 0; b < REF_BITS; b++) begin
      if (r3_q[b]) nr4_d = REF_NW'(b);
    end
  end

  assign shp = p4_q << (NW'(PW - 1) - np4_q);
  assign shr = r4_q << (REF_NW'(REF_BITS - 1) - nr4_q);
  assign mr5_d = shr;

  generate
    if (PW >= MANT_BITS) begin : g_mant_top
      assign mp5_d = shp[PW-1 -: MANT_BITS];
    end else begin : g_mant_pad
      assign mp5_d = {shp, {(MANT_BITS-PW){1'b0}}};
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
    end else if (en) begin
      c1_q <= '{valid: in_i.valid, last: in_i.last_sample, db: db_q, zero: 1'b0};
      c2_q <= c1_q;
      c3_q <= '{valid: c2_q.valid, last: c2_q.last, db: c2_q.db,
                zero: ((si2_q | sq2_q) == '0)};
      c4_q <= c3_q;
      c5_q <= c4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i1_q  <= in_i.in_phase_sample;
      q1_q  <= in_i.quadrature_sample;
      // full-width signed squares
      si2_q <= PW'($unsigned(PW'(i1_q) * PW'(i1_q)));
      sq2_q <= PW'($unsigned(PW'(q1_q) * PW'(q1_q)));
      p3_q  <= si2_q + sq2_q;
      r3_q  <= (ref_q == '0) ? REF_BITS'(1) : ref_q;
      p4_q  <= p3_q;
      r4_q  <= r3_q;
      np4_q <= np4_d;
      nr4_q <= nr4_d;
      p5_q  <= p4_q;
      mp5_q <= mp5_d;
      mr5_q <= mr5_d;
      np5_q <= np4_q;
      nr5_q <= nr4_q;
    end
  end

  // chain of cells
  ctl_t                 ctl_c  [NC+1];
  logic [PW-1:0]        rem_c  [NC+1];
  logic [SB-1:0]        root_c [NC+1];
  logic [MANT_BITS-1:0] mp_c   [NC+1];
  logic [MANT_BITS-1:0] mr_c   [NC+1];
  logic [FRAC_BITS-1:0] fp_c   [NC+1];
  logic [FRAC_BITS-1:0] fr_c   [NC+1];
  logic [NW-1:0]        np_c   [NC+1];
  logic [REF_NW-1:0]    nr_c   [NC+1];

  assign ctl_c[0]  = c5_q;
  assign rem_c[0]  = p5_q;
  assign root_c[0] = '0;
  assign mp_c[0]   = mp5_q;
  assign mr_c[0]   = mr5_q;
  assign fp_c[0]   = '0;
  assign fr_c[0]   = '0;
  assign np_c[0]   = np5_q;
  assign nr_c[0]   = nr5_q;

  generate
    for (genvar k = 0; k < NC; k++) begin : g_cell
      iqmdb_cell #(.SB(SB), .PW(PW), .NW(NW), .IDX(k)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .ctl_i  (ctl_c[k]),
        .rem_i  (rem_c[k]),
        .root_i (root_c[k]),
        .mp_i   (mp_c[k]),
        .mr_i   (mr_c[k]),
        .fp_i   (fp_c[k]),
        .fr_i   (fr_c[k]),
        .np_i   (np_c[k]),
        .nr_i   (nr_c[k]),
        .ctl_o  (ctl_c[k+1]),
        .rem_o  (rem_c[k+1]),
        .root_o (root_c[k+1]),
        .mp_o   (mp_c[k+1]),
        .mr_o   (mr_c[k+1]),
        .fp_o   (fp_c[k+1]),
        .fr_o   (fr_c[k+1]),
        .np_o   (np_c[k+1]),
        .nr_o   (nr_c[k+1])
      );
    end
  endgenerate

  // stage 6: log difference times dB scale
  ctl_t                  c6_q;
  logic signed [PRW-1:0] prod6_q;
  logic [SB-1:0]         root6_q;
  logic signed [DW-1:0]  diff;

  assign diff = $signed({1'b0, LNW'(np_c[NC]), fp_c[NC]})
              - $signed({1'b0, LNW'(nr_c[NC]), fr_c[NC]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c6_q <= '0;
    end else if (en) begin
      c6_q <= ctl_c[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod6_q <= PRW'(diff) * PRW'(DB_SCALE);
      root6_q <= root_c[NC];
    end
  end

  // stage 7: round, saturate, select
  logic                  neg;
  logic [PRW-1:0]        absv;
  logic [PRW-1:0]        rsum;
  logic [RW-1:0]         rnd;
  logic signed [RES_W-1:0] db_val, res_d;
  logic [31:0]           rootx;
  logic [15:0]           mag;

  always_comb begin
    neg   = prod6_q[PRW-1];
    absv  = neg ? PRW'(-prod6_q) : PRW'(prod6_q);
    rsum  = absv + (PRW'(1) << 31);
    rnd   = rsum[PRW-1:32];
    if (!neg) begin
      db_val = (rnd > RW'(32767)) ? DB_MAX : $signed(RES_W'(rnd));
    end else begin
      db_val = (rnd > RW'(32768)) ? DB_MIN : -$signed(RES_W'(rnd));
    end
    if (c6_q.zero) db_val = DB_MIN;
    rootx = 32'(root6_q);
    mag   = (rootx > 32'(MAG_MAX)) ? MAG_MAX : rootx[15:0];
    res_d = c6_q.db ? db_val : $signed({1'b0, mag});
  end

  logic                    out_last_q, out_db_q;
  logic signed [RES_W-1:0] out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= c6_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_res_q  <= res_d;
      out_last_q <= c6_q.last;
      out_db_q   <= c6_q.db;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_res_q;
  assign out_o.last_result  = out_last_q;

  // a valid beat leaving the multiply stage lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && c6_q.valid |=> out_valid_q)
    else $error("result beat dropped at output register");

  // magnitude results are never negative codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_db_q |-> !out_res_q[RES_W-1])
    else $error("magnitude result out of range");

  // zero power in dB mode yields the floor code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && c6_q.valid && c6_q.db && c6_q.zero |=> out_res_q == DB_MIN)
    else $error("zero power did not saturate");

endmodule

// ===== src/iqmdb_cell.sv =====
// ----------------------------------------------------------------------------
// iqmdb_cell
// One step of the chain: at most one square-root digit of the sample power
// and at most one log2 fraction bit each for the sample and reference powers.
// ----------------------------------------------------------------------------
module iqmdb_cell
  import iqmdb_pkg::*;
#(
  parameter int SB  = 16,
  parameter int PW  = 32,
  parameter int NW  = 5,
  parameter int IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  ctl_t                 ctl_i,
  input  logic [PW-1:0]        rem_i,
  input  logic [SB-1:0]        root_i,
  input  logic [MANT_BITS-1:0] mp_i,
  input  logic [MANT_BITS-1:0] mr_i,
  input  logic [FRAC_BITS-1:0] fp_i,
  input  logic [FRAC_BITS-1:0] fr_i,
  input  logic [NW-1:0]        np_i,
  input  logic [REF_NW-1:0]    nr_i,
  output ctl_t                 ctl_o,
  output logic [PW-1:0]        rem_o,
  output logic [SB-1:0]        root_o,
  output logic [MANT_BITS-1:0] mp_o,
  output logic [MANT_BITS-1:0] mr_o,
  output logic [FRAC_BITS-1:0] fp_o,
  output logic [FRAC_BITS-1:0] fr_o,
  output logic [NW-1:0]        np_o,
  output logic [REF_NW-1:0]    nr_o
);

  ctl_t                 ctl_q;
  logic [PW-1:0]        rem_d, rem_q;
  logic [SB-1:0]        root_d, root_q;
  logic [MANT_BITS-1:0] mp_d, mp_q, mr_d, mr_q;
  logic [FRAC_BITS-1:0] fp_d, fp_q, fr_d, fr_q;
  logic [NW-1:0]        np_q;
  logic [REF_NW-1:0]    nr_q;

  generate
    if (IDX < SB) begin : g_sqrt
      localparam int B = SB - 1 - IDX;
      logic [PW:0] trial;
      always_comb begin
        // trial = 2*root*2^B + 2^(2B), root holding only bits above B
        trial  = ((PW+1)'(root_i) << (B + 1)) + ((PW+1)'(1) << (2 * B));
        rem_d  = rem_i;
        root_d = root_i;
        if ({1'b0, rem_i} >= trial) begin
          rem_d     = PW'({1'b0, rem_i} - trial);
          root_d[B] = 1'b1;
        end
      end
    end else begin : g_sqrt_pass
      assign rem_d  = rem_i;
      assign root_d = root_i;
    end

    if (IDX < FRAC_BITS) begin : g_log
      logic [2*MANT_BITS-1:0] sqp, sqr;
      logic [MANT_BITS:0]     m2p, m2r;
      always_comb begin
        sqp  = {{MANT_BITS{1'b0}}, mp_i} * {{MANT_BITS{1'b0}}, mp_i};
        sqr  = {{MANT_BITS{1'b0}}, mr_i} * {{MANT_BITS{1'b0}}, mr_i};
        m2p  = sqp[2*MANT_BITS-1:MANT_BITS-1];
        m2r  = sqr[2*MANT_BITS-1:MANT_BITS-1];
        mp_d = m2p[MANT_BITS] ? m2p[MANT_BITS:1] : m2p[MANT_BITS-1:0];
        mr_d = m2r[MANT_BITS] ? m2r[MANT_BITS:1] : m2r[MANT_BITS-1:0];
        fp_d = {fp_i[FRAC_BITS-2:0], m2p[MANT_BITS]};
        fr_d = {fr_i[FRAC_BITS-2:0], m2r[MANT_BITS]};
      end
    end else begin : g_log_pass
      assign mp_d = mp_i;
      assign mr_d = mr_i;
      assign fp_d = fp_i;
      assign fr_d = fr_i;
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      mp_q   <= mp_d;
      mr_q   <= mr_d;
      fp_q   <= fp_d;
      fr_q   <= fr_d;
      np_q   <= np_i;
      nr_q   <= nr_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign mp_o   = mp_q;
  assign mr_o   = mr_q;
  assign fp_o   = fp_q;
  assign fr_o   = fr_q;
  assign np_o   = np_q;
  assign nr_o   = nr_q;

endmodule

// ===== tb/iq_magnitude_and_db_power_tb.sv =====
// ----------------------------------------------------------------------------
// iq_magnitude_and_db_power_tb
// Drives I/Q sample beats with random gaps and result stalls, predicts each
// magnitude or dB result in fixed point, and compares it field by field.
// ----------------------------------------------------------------------------
module iq_magnitude_and_db_power_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iqmdb_pkg::*;

  localparam int SAMPLE_BITS = 16;
  localparam int LATENCY     = 23;
  localparam int MAX_CYCLES  = 400000;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic                    last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  iqmdb_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  iqmdb_out_if out_ch ();

  iq_magnitude_and_db_power #(.SAMPLE_BITS(SAMPLE_BITS)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  // predictor copy of the registers
  logic        db_mode;
  logic [31:0] ref_pow;

  result_t expected_results[$];
  int errors, n_sent, n_checked, n_db, n_mag, n_last;
  longint cycles;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_phase_sample = '0;
    in_ch.quadrature_sample = '0;
    in_ch.last_sample = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("** iq_magnitude_and_db_power: FAILED **");
      $finish;
    end
  end
  initial cycles = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint log2_fixed(logic [63:0] v);
    int n;
    logic [63:0] m;
    logic [127:0] sq;
    logic [15:0] frac;
    n = 0;
    frac = 0;
    while (n < 63 && (v >> (n + 1)) != 0) n++;
    m = (n > 31) ? (v >> (n - 31)) : (v << (31 - n));
    for (int k = 0; k < 16; k++) begin
      sq = m * m;
      m = sq[94:31];
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac[0] = 1'b1;
        m >>= 1;
      end
    end
    return (longint'(n) << 16) | longint'(frac);
  endfunction

  function automatic logic signed [RES_W-1:0] power_to_db(logic [63:0] p, logic [31:0] rp);
    longint d, prod, q;
    if (p == 0) return DB_MIN;
    d = log2_fixed(p) - log2_fixed({32'd0, rp});
    prod = d * longint'(DB_SCALE);
    if (prod < 0) q = -((-prod + (64'sd1 <<< 31)) >>> 32);
    else q = (prod + (64'sd1 <<< 31)) >>> 32;
    if (q < -32768) q = -32768;
    if (q > 32767) q = 32767;
    return q[RES_W-1:0];
  endfunction

  function automatic result_t predict_result(logic signed [15:0] i_s, logic signed [15:0] q_s,
                                             logic lst);
    result_t r;
    logic [63:0] p, mag;
    p = 64'(longint'(i_s) * i_s + longint'(q_s) * q_s);
    if (db_mode) begin
      r.value = power_to_db(p, (ref_pow == 0) ? 32'd1 : ref_pow);
    end else begin
      mag = int_sqrt(p);
      if (mag > 65535) mag = 65535;
      r.value = {1'b0, mag[15:0]};
    end
    r.last = lst;
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_OUTPUT_IN_DB) db_mode = data[0];
    else ref_pow = data;
  endtask

  task automatic send_sample(logic signed [15:0] i_s, logic signed [15:0] q_s, logic lst);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_phase_sample <= i_s;
    in_ch.quadrature_sample <= q_s;
    in_ch.last_sample <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_results.push_back(predict_result(i_s, q_s, lst));
    n_sent++;
    if (db_mode) n_db++; else n_mag++;
    @(negedge clk_i);
  endtask

  // called right at the negedge that ends a send, so valid drops before the next edge
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // result side: random stalls, check at rising edge
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: value=%0d", out_ch.result_value);
        errors++;
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (out_ch.result_value !== e.value) begin
          $error("result_value: expected %0d, got %0d", e.value, out_ch.result_value);
          errors++;
        end
        if (out_ch.last_result !== e.last) begin
          $error("last_result: expected %0b, got %0b", e.last, out_ch.last_result);
          errors++;
        end
        if (e.last) n_last++;
        n_checked++;
      end
    end
  end

  task automatic test_magnitude_edges();
    write_reg(REG_OUTPUT_IN_DB, 32'd0);
    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(-16'sd32768, -16'sd32768, 1'b0);
    send_sample(16'sd32767, 16'sd32767, 1'b1);
    send_sample(-16'sd32768, 16'sd0, 1'b0);
    send_sample(16'sd1, -16'sd1, 1'b0);
    send_sample(16'sd3, 16'sd4, 1'b1);
    send_sample(16'sh5555, -16'sh5556, 1'b0);
    drain();
  endtask

  task automatic test_db_edges();
    write_reg(REG_OUTPUT_IN_DB, 32'd1);
    write_reg(REG_REFERENCE_POWER, 32'd0);   // zero reference acts as one
    send_sample(16'sd0, 16'sd0, 1'b1);       // zero power
    send_sample(16'sd1, 16'sd0, 1'b0);
    send_sample(-16'sd32768, -16'sd32768, 1'b0);
    drain();
    write_reg(REG_REFERENCE_POWER, 32'h8000_0000);
    send_sample(16'sd1, 16'sd0, 1'b0);
    send_sample(-16'sd32768, -16'sd32768, 1'b1);
    send_sample(16'sd0, 16'sd0, 1'b0);
    drain();
    write_reg(REG_REFERENCE_POWER, 32'd1);
    send_sample(16'sd32767, -16'sd32768, 1'b0);
    send_sample(-16'sd1, 16'sd1, 1'b1);
    drain();
  endtask

  task automatic test_random_phase(int count, logic mode, logic [31:0] rp);
    logic signed [15:0] a, b;
    write_reg(REG_OUTPUT_IN_DB, {31'd0, mode});
    write_reg(REG_REFERENCE_POWER, rp);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 4))
        0: begin a = $urandom_range(0, 15) - 8; b = $urandom_range(0, 15) - 8; end
        1: begin a = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767; b = $urandom; end
        default: begin a = $urandom; b = $urandom; end
      endcase
      send_sample(a, b, $urandom_range(0, 7) == 0);
      if (k == count / 2 && mode) begin
        drain();   // hold off until the pipe is empty
      end
    end
    drain();
  endtask

  initial begin
    errors = 0; n_sent = 0; n_checked = 0; n_db = 0; n_mag = 0; n_last = 0;
    db_mode = 1'b0;
    ref_pow = 32'd1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_magnitude_edges();
    test_db_edges();
    test_random_phase(200, 1'b0, 32'd1);
    test_random_phase(150, 1'b1, 32'd1);
    test_random_phase(150, 1'b1, $urandom);
    test_random_phase(100, 1'b1, 32'h8000_0000);
    test_random_phase(100, 1'b0, 32'd12345);
    $display("Checked %0d of %0d beats: %0d magnitude, %0d dB, %0d frame ends.",
             n_checked, n_sent, n_mag, n_db, n_last);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** iq_magnitude_and_db_power: PASSED **");
    end else begin
      $display("** iq_magnitude_and_db_power: FAILED **");
    end
    $finish;
  end

endmodule

// ===== iq_magnitude_and_db_power.f =====
src/iqmdb_pkg.sv
src/iqmdb_if.sv
src/iqmdb_cell.sv
src/iq_magnitude_and_db_power.sv
tb/iq_magnitude_and_db_power_tb.sv
